// ===== rtl/bbcp_pkg.sv =====
// package for the buffer cache replacement block
// opcodes, status codes, sequencer states and size constants; no dependencies
`default_nettype none
package bbcp_pkg;
    localparam int NUM_BUFFERS_DEF = 64;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SETFLG  = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_FREE_RELEASE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_WALK_RD,
        S_WALK_ENT,
        S_WALK_CHK,
        S_ALLOC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SLOT_RD,
        S_SLOT_WR,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/bbcp_ram.sv =====
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module bbcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/block_buffer_cache_policy.sv =====
// buffer cache tag store with recency-ordered replacement
// uses bbcp_pkg and bbcp_ram (entry ram and recency-order ram)
//
// usage: one request enters on the s_ channel, one result leaves on m_.
//   s_tdata  = device, block_number, buffer_slot, new_dirty, new_locked,
//              new_valid_data from bit 0 up, opcode in s_tuser
//   m_tdata  = chosen_slot, was_hit, data_current, status from bit 0 up
// a request is taken only when the sequencer is idle; s_tready is low
// while it works. the block handles one request at a time.
// steps: a no-op goes straight to the result; release / set flags read the
//   slot's entry and write it back (a slot beyond the table skips the write).
//   get: a tag search reads entry after entry and stops at a hit; a miss
//   (device 0 skips the search) walks the recency order until a clean free
//   entry or the tail, allocates the least bad free entry, then shifts the
//   order down to the tail.
// the walk and shift share the order ram; the walk also reads the entry ram.
// reset: a clearing pass over every entry writes zero entries and the
// identity order; s_tready stays low until it ends.
// stall: the result is held in an output register until m_tready; the
// block takes no new request until the result has left.
`default_nettype none
module block_buffer_cache_policy #(
    parameter int NUM_BUFFERS = bbcp_pkg::NUM_BUFFERS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // device[15:0], block_number[39:16], buffer_slot[45:40], new_dirty[46],
    // new_locked[47], new_valid_data[48], zeros above
    input  wire logic [55:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // chosen_slot[5:0], was_hit[6], data_current[7], status[9:8], zeros above
    output logic [15:0]      m_tdata
);
    import bbcp_pkg::*;

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam int CW = AW + 1;
    // entry word: dev16, blk24, cnt8, dirty, lock, cur
    localparam int EW = 16 + 24 + 8 + 3;
    localparam logic [CW-1:0] LAST = CW'(NUM_BUFFERS - 1);

    state_t state_reg, state_next;

    logic [1:0]  op_reg;
    logic [15:0] dev_reg;
    logic [23:0] blk_reg;
    logic [5:0]  slot_reg;
    logic [2:0]  flg_reg;

    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] best_pos_reg, best_pos_next;
    logic [AW-1:0] best_ent_reg, best_ent_next;
    logic [1:0]    best_bad_reg, best_bad_next;
    logic          found_reg, found_next;
    // lock flag of the best candidate so far
    logic          lock_best_reg;

    logic [5:0] r_slot_reg, r_slot_next;
    logic       r_hit_reg, r_hit_next;
    logic       r_cur_reg, r_cur_next;
    status_t    r_st_reg, r_st_next;
    logic       cap_in;

    // entry ram
    logic          e_we;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;
    // order ram
    logic          o_we;
    logic [AW-1:0] o_waddr, o_raddr;
    logic [AW-1:0] o_wdata, o_rdata;

    bbcp_ram #(.WIDTH(EW), .DEPTH(NUM_BUFFERS)) u_ent (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );
    bbcp_ram #(.WIDTH(AW), .DEPTH(NUM_BUFFERS)) u_ord (
        .aclk(aclk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    // entry word fields
    logic [15:0] rd_dev;
    logic [23:0] rd_blk;
    logic [7:0]  rd_cnt;
    logic        rd_dirty, rd_lock, rd_cur;
    logic [1:0]  rd_bad;
    assign {rd_dev, rd_blk, rd_cnt, rd_dirty, rd_lock, rd_cur} = e_rdata;
    assign rd_bad = {rd_dirty, rd_lock};

    logic slot_ok;
    assign slot_ok = ({26'd0, slot_reg} < 32'(NUM_BUFFERS));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, r_st_reg, r_cur_reg, r_hit_reg, r_slot_reg};
    assign cap_in   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_in) begin
            op_reg   <= s_tuser;
            dev_reg  <= s_tdata[15:0];
            blk_reg  <= s_tdata[39:16];
            slot_reg <= s_tdata[45:40];
            flg_reg  <= s_tdata[48:46];
        end
        best_pos_reg <= best_pos_next;
        best_ent_reg <= best_ent_next;
        best_bad_reg <= best_bad_next;
        found_reg    <= found_next;
        r_slot_reg   <= r_slot_next;
        r_hit_reg    <= r_hit_next;
        r_cur_reg    <= r_cur_next;
        r_st_reg     <= r_st_next;
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        best_pos_next = best_pos_reg;
        best_ent_next = best_ent_reg;
        best_bad_next = best_bad_reg;
        found_next    = found_reg;
        r_slot_next   = r_slot_reg;
        r_hit_next    = r_hit_reg;
        r_cur_next    = r_cur_reg;
        r_st_next     = r_st_reg;
        e_we    = 1'b0;
        e_waddr = idx_reg[AW-1:0];
        e_wdata = e_rdata;
        e_raddr = idx_reg[AW-1:0];
        o_we    = 1'b0;
        o_waddr = idx_reg[AW-1:0];
        o_wdata = o_rdata;
        o_raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_INIT: begin
                // clearing pass
                e_we    = 1'b1;
                e_wdata = '0;
                o_we    = 1'b1;
                o_wdata = idx_reg[AW-1:0];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                idx_next   = '0;
                found_next = 1'b0;
                if (cap_in) begin
                    unique case (opcode_t'(s_tuser))
                        OP_GET: begin
                            state_next = (s_tdata[15:0] != 16'd0) ? S_SRCH_RD
                                                                  : S_WALK_RD;
                        end
                        OP_RELEASE, OP_SETFLG: state_next = S_SLOT_RD;
                        default: begin
                            r_slot_next = s_tdata[45:40];
                            r_hit_next  = 1'b0;
                            r_cur_next  = 1'b0;
                            r_st_next   = ST_OK;
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end
            S_SRCH_RD: begin
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (rd_dev == dev_reg && rd_blk == blk_reg) begin
                    e_we = 1'b1;
                    e_wdata = {rd_dev, rd_blk,
                               (rd_cnt == 8'hFF) ? rd_cnt : rd_cnt + 8'd1,
                               rd_dirty, rd_lock, rd_cur};
                    r_slot_next = 6'(idx_reg[AW-1:0]);
                    r_hit_next  = 1'b1;
                    r_cur_next  = rd_cur;
                    r_st_next   = ST_OK;
                    state_next  = S_OUT;
                end else if (idx_reg == LAST) begin
                    idx_next   = '0;
                    state_next = S_WALK_RD;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end
            S_WALK_RD: begin
                state_next = S_WALK_ENT;
            end
            S_WALK_ENT: begin
                // order entry at this position selects the entry to read
                e_raddr    = o_rdata;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (rd_cnt == 8'd0 && (!found_reg || rd_bad < best_bad_reg)) begin
                    found_next    = 1'b1;
                    best_pos_next = idx_reg;
                    best_ent_next = o_rdata;
                    best_bad_next = rd_bad;
                end
                if ((rd_cnt == 8'd0 && rd_bad == 2'd0) || idx_reg == LAST) begin
                    state_next = S_ALLOC;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_ALLOC: begin
                r_hit_next = 1'b0;
                r_cur_next = 1'b0;
                if (!found_reg) begin
                    r_slot_next = '0;
                    r_st_next   = ST_NO_FREE;
                    state_next  = S_OUT;
                end else begin
                    e_we    = 1'b1;
                    e_waddr = best_ent_reg;
                    e_wdata = {dev_reg, blk_reg, 8'd1, 1'b0, lock_best_reg, 1'b0};
                    r_slot_next = 6'(best_ent_reg);
                    r_st_next   = ST_OK;
                    idx_next    = best_pos_reg;
                    state_next  = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (idx_reg == LAST) begin
                    o_we    = 1'b1;
                    o_wdata = best_ent_reg;
                    state_next = S_OUT;
                end else begin
                    o_raddr    = idx_reg[AW-1:0] + 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_we     = 1'b1;
                o_wdata  = o_rdata;
                idx_next = idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_SLOT_RD: begin
                e_raddr = AW'(slot_reg);
                if (!slot_ok) begin
                    r_slot_next = slot_reg;
                    r_hit_next  = 1'b0;
                    r_cur_next  = 1'b0;
                    r_st_next   = ST_OK;
                    state_next  = S_OUT;
                end else begin
                    state_next = S_SLOT_WR;
                end
            end
            S_SLOT_WR: begin
                e_waddr     = AW'(slot_reg);
                r_slot_next = slot_reg;
                r_hit_next  = 1'b0;
                r_st_next   = ST_OK;
                if (op_reg == OP_SETFLG) begin
                    e_we    = 1'b1;
                    e_wdata = {rd_dev, rd_blk, rd_cnt, flg_reg[0], flg_reg[1], flg_reg[2]};
                    r_cur_next = flg_reg[2];
                end else begin
                    r_cur_next = rd_cur;
                    if (rd_cnt == 8'd0) begin
                        r_st_next = ST_FREE_RELEASE;
                    end else begin
                        e_we    = 1'b1;
                        e_wdata = {rd_dev, rd_blk, rd_cnt - 8'd1, rd_dirty, rd_lock, rd_cur};
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // lock flag of the chosen entry: read data still holds it only if the
    // chosen entry was the last one read, so a lock register keeps it
    always_ff @(posedge aclk) begin
        if (state_reg == S_WALK_CHK && rd_cnt == 8'd0 &&
            (!found_reg || rd_bad < best_bad_reg)) begin
            lock_best_reg <= rd_lock;
        end
    end

    // assertions
    a_out_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_st_reg == ST_OK || r_st_reg == ST_NO_FREE ||
                      r_st_reg == ST_FREE_RELEASE))
        else $error("bad status code");
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_hit_reg) |-> (r_st_reg == ST_OK && op_reg == OP_GET))
        else $error("hit with bad status");
    a_nofree: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_st_reg == ST_NO_FREE) |-> (r_slot_reg == 6'd0 && !r_cur_reg))
        else $error("no-free result not cleared");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("ready while result pending");
endmodule
`default_nettype wire

// ===== sim/block_buffer_cache_policy_test.sv =====
// self-checking testbench for the buffer cache replacement block
// drives get / release / set-flags / no-op requests, predicts results in-house; needs bbcp_pkg and rtl
`timescale 1ns / 100ps
`default_nettype none
module block_buffer_cache_policy_test;
    import bbcp_pkg::*;

    localparam int NBUF = NUM_BUFFERS_DEF;
    localparam int CYCLE_LIMIT = 5000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NOP;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // one request and one result
    typedef struct packed {
        opcode_t     op;
        logic [15:0] dev;
        logic [23:0] blk;
        logic [5:0]  slot;
        logic        nd;
        logic        nl;
        logic        nv;
    } cache_req_t;

    typedef struct packed {
        logic [5:0] slot;
        logic       hit;
        logic       cur;
        status_t    st;
    } cache_resp_t;

    // directed row: request, plus a typed-in answer where it is obvious
    typedef struct packed {
        cache_req_t  rq;
        logic        fixed;
        cache_resp_t ans;
    } dir_row_t;

    always #5 aclk = ~aclk;

    block_buffer_cache_policy dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata),   // device, block_number, buffer_slot, dirty, locked, valid
        .s_tuser(s_tuser),   // opcode
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)    // chosen_slot, was_hit, data_current, status
    );

    // shadow copy of the cache tag store
    logic [15:0] sh_dev  [NBUF];
    logic [23:0] sh_blk  [NBUF];
    logic [7:0]  sh_cnt  [NBUF];
    logic        sh_dirty[NBUF];
    logic        sh_lock [NBUF];
    logic        sh_cur  [NBUF];
    logic [5:0]  sh_lru  [NBUF];

    cache_resp_t pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          hold_off = 1'b0;

    function automatic void clear_shadow();
        for (int i = 0; i < NBUF; i++) begin
            sh_dev[i] = '0; sh_blk[i] = '0; sh_cnt[i] = '0;
            sh_dirty[i] = 0; sh_lock[i] = 0; sh_cur[i] = 0;
            sh_lru[i] = 6'(i);
        end
    endfunction

    // work out the result of one request and update the shadow store
    function automatic cache_resp_t predict_cache(cache_req_t rq);
        cache_resp_t r;
        int best_pos, best_bad, bad, e;
        bit found;
        r = '{slot: rq.slot, hit: 1'b0, cur: 1'b0, st: ST_OK};
        case (rq.op)
            OP_GET: begin
                // tag search; device zero never hits
                if (rq.dev != 0) begin
                    for (int i = 0; i < NBUF; i++) begin
                        if (sh_dev[i] == rq.dev && sh_blk[i] == rq.blk) begin
                            if (sh_cnt[i] != 8'hFF) sh_cnt[i]++;
                            r = '{slot: 6'(i), hit: 1'b1, cur: sh_cur[i], st: ST_OK};
                            return r;
                        end
                    end
                end
                // walk recency order for the least bad free entry
                found = 0; best_pos = 0; best_bad = 0;
                for (int p = 0; p < NBUF; p++) begin
                    e = sh_lru[p];
                    if (sh_cnt[e] != 0) continue;
                    bad = 2 * sh_dirty[e] + sh_lock[e];
                    if (!found || bad < best_bad) begin
                        found = 1; best_pos = p; best_bad = bad;
                        if (bad == 0) break;
                    end
                end
                if (!found) begin
                    r = '{slot: 6'd0, hit: 1'b0, cur: 1'b0, st: ST_NO_FREE};
                    return r;
                end
                e = sh_lru[best_pos];
                sh_cnt[e] = 8'd1; sh_dirty[e] = 0; sh_cur[e] = 0;
                sh_dev[e] = rq.dev; sh_blk[e] = rq.blk;
                for (int p = best_pos; p < NBUF - 1; p++) sh_lru[p] = sh_lru[p + 1];
                sh_lru[NBUF - 1] = 6'(e);
                r.slot = 6'(e);
            end
            OP_RELEASE: begin
                r.cur = sh_cur[rq.slot];
                if (sh_cnt[rq.slot] == 0) r.st = ST_FREE_RELEASE;
                else sh_cnt[rq.slot]--;
            end
            OP_SETFLG: begin
                sh_dirty[rq.slot] = rq.nd;
                sh_lock[rq.slot] = rq.nl;
                sh_cur[rq.slot] = rq.nv;
                r.cur = rq.nv;
            end
            default: ;
        endcase
        return r;
    endfunction

    // slot currently holding a tag, from the shadow store
    function automatic logic [5:0] predict_cache_slot(logic [15:0] d, logic [23:0] b);
        for (int i = 0; i < NBUF; i++)
            if (sh_dev[i] == d && sh_blk[i] == b) return 6'(i);
        return 6'd0;
    endfunction

    // hand one request over and log its expected result
    task automatic send_request(cache_req_t rq, logic fixed, cache_resp_t ans);
        cache_resp_t p;
        // random gap before one request in four, on average
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.op;
        s_tdata  <= {7'd0, rq.nv, rq.nl, rq.nd, rq.slot, rq.blk, rq.dev};
        do @(posedge aclk); while (!s_tready);
        p = predict_cache(rq);
        if (fixed && p != ans)
            $display("directed row answer differs from prediction for op %s", rq.op.name());
        pending_results.push_back(fixed ? ans : p);
    endtask

    function automatic cache_req_t rand_req(int hot_devs);
        cache_req_t rq;
        int k = $urandom_range(0, 99);
        rq.dev  = 16'($urandom_range(1, hot_devs));
        rq.blk  = 24'($urandom_range(0, 40));
        rq.slot = 6'($urandom_range(0, NBUF - 1));
        {rq.nd, rq.nl, rq.nv} = 3'($urandom);
        if (k < 45) rq.op = OP_GET;
        else if (k < 80) rq.op = OP_RELEASE;
        else if (k < 95) rq.op = OP_SETFLG;
        else rq.op = OP_NOP;
        // noise: full-range tags now and then
        if ($urandom_range(0, 9) == 0) begin
            rq.dev = 16'($urandom);
            rq.blk = 24'($urandom);
        end
        return rq;
    endfunction

    // result checker with its own stall pattern
    always @(posedge aclk) begin
        cache_resp_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.slot = m_tdata[5:0];
            got.hit  = m_tdata[6];
            got.cur  = m_tdata[7];
            got.st   = status_t'(m_tdata[9:8]);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got != want || m_tdata[15:10] != 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: slot %0d/%0d hit %0b/%0b cur %0b/%0b st %0d/%0d",
                                 want.slot, got.slot, want.hit, got.hit,
                                 want.cur, got.cur, want.st, got.st);
                end
            end
        end
        m_tready <= !hold_off && (cycles % 13 < 9 || $urandom_range(0, 1) == 1);
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        wait (aresetn);
        repeat (5000) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (1500) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // watchdog and run end
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        dir_row_t dir_rows[$];
        cache_req_t rq;
        cache_resp_t none;
        int wait_cnt;
        none = '0;
        clear_shadow();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        dir_rows.push_back('{'{OP_RELEASE, 16'd0, 24'd0, 6'd5, 0,0,0}, 1,
                             '{6'd5, 0, 0, ST_FREE_RELEASE}});
        dir_rows.push_back('{'{OP_GET, 16'hFFFF, 24'hFFFFFF, 6'd0, 0,0,0}, 1,
                             '{6'd0, 0, 0, ST_OK}});
        dir_rows.push_back('{'{OP_GET, 16'hFFFF, 24'hFFFFFF, 6'd0, 0,0,0}, 1,
                             '{6'd0, 1, 0, ST_OK}});
        dir_rows.push_back('{'{OP_SETFLG, 16'd0, 24'd0, 6'd0, 1,1,1}, 1,
                             '{6'd0, 0, 1, ST_OK}});
        dir_rows.push_back('{'{OP_GET, 16'hFFFF, 24'hFFFFFF, 6'd0, 0,0,0}, 1,
                             '{6'd0, 1, 1, ST_OK}});
        // device zero never hits
        dir_rows.push_back('{'{OP_GET, 16'd0, 24'd0, 6'd0, 0,0,0}, 0, none});
        dir_rows.push_back('{'{OP_GET, 16'd0, 24'd0, 6'd0, 0,0,0}, 0, none});
        dir_rows.push_back('{'{OP_NOP, 16'h5555, 24'hAAAAAA, 6'd63, 1,1,1}, 1,
                             '{6'd63, 0, 0, ST_OK}});
        dir_rows.push_back('{'{OP_SETFLG, 16'd0, 24'd0, 6'd63, 1,0,0}, 0, none});
        dir_rows.push_back('{'{OP_SETFLG, 16'd0, 24'd0, 6'd3, 0,1,0}, 0, none});
        dir_rows.push_back('{'{OP_RELEASE, 16'd0, 24'd0, 6'd0, 0,0,0}, 0, none});
        dir_rows.push_back('{'{OP_RELEASE, 16'd0, 24'd0, 6'd0, 0,0,0}, 0, none});
        dir_rows.push_back('{'{OP_GET, 16'd1, 24'd1, 6'd0, 0,0,0}, 0, none});
        foreach (dir_rows[i]) send_request(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].ans);

        // count saturation: request one tag 300 times
        rq = '{OP_GET, 16'h1234, 24'h000042, 6'd0, 0, 0, 0};
        repeat (300) send_request(rq, 0, none);
        rq.op = OP_RELEASE; rq.slot = predict_cache_slot(16'h1234, 24'h42);
        repeat (256) send_request(rq, 0, none);

        // fill every entry so the table runs out of free buffers
        for (int i = 0; i < NBUF + 4; i++) begin
            rq = '{OP_GET, 16'h7000, 24'(i + 1000), 6'd0, 0, 0, 0};
            send_request(rq, 0, none);
        end
        for (int i = 0; i < NBUF; i++) begin
            rq = '{OP_SETFLG, 16'd0, 24'd0, 6'(i), 1'($urandom), 1'($urandom), 1'($urandom)};
            send_request(rq, 0, none);
        end

        // random traffic over a small tag space so hits and releases land
        for (int n = 0; n < 1000; n++) send_request(rand_req(n < 500 ? 3 : 12), 0, none);
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (500) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
